@@ hdl/nnm2d_pkg.sv @@
// shared constants, control structs and opcodes of the 2-d nearest neighbour matcher
// no dependencies; used by every module of the block
`default_nettype none

package nnm2d_pkg;

  // reference store depth and the widths that follow from it
  localparam int REF_DEPTH = 1024;
  localparam int ADDR_W    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(REF_DEPTH + 1);

  // fixed field widths
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 10;
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  // width for comparisons against the depth
  localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  // transaction opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              load;
    logic              query;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/nnm2d_ctrl.sv @@
// controller of the nearest neighbour matcher: config register, scan counter, state machine
// depends on nnm2d_pkg
`default_nettype none

module nnm2d_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic                          op_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [nnm2d_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                               cfg_ready_o,
  output logic                               busy,
  output logic                               result_valid_o,
  output nnm2d_pkg::ctrl_cmd_t               cmd_o,
  input  wire nnm2d_pkg::dp_status_t         status_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [nnm2d_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [nnm2d_pkg::CFG_W-1:0]      ref_count_q;
  logic [nnm2d_pkg::CNT_W-1:0]      n_cnt;

  assign cfg_ready_o = 1'b1;

  // count saturated at the store depth
  always_comb begin
    if (nnm2d_pkg::CMP_W'(ref_count_q) > nnm2d_pkg::CMP_W'(nnm2d_pkg::REF_DEPTH)) begin
      n_cnt = nnm2d_pkg::CNT_W'(nnm2d_pkg::REF_DEPTH);
    end else begin
      n_cnt = nnm2d_pkg::CNT_W'(ref_count_q);
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.rd_addr = cnt_q[nnm2d_pkg::ADDR_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start && (op_i == nnm2d_pkg::OP_LOAD)) begin
          cmd_o.load = 1'b1;
        end
        if (start && (op_i == nnm2d_pkg::OP_QUERY)) begin
          cmd_o.query = 1'b1;
          cnt_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == n_cnt) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
          cnt_d       = cnt_q + nnm2d_pkg::CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ref_count_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ref_count_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/nnm2d_dp.sv @@
// datapath of the nearest neighbour matcher: reference store, distance pipeline, best tracker
// depends on nnm2d_pkg
`default_nettype none

module nnm2d_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire nnm2d_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [nnm2d_pkg::IDX_W-1:0]     point_index_i,
  input  wire logic [nnm2d_pkg::COORD_W-1:0]   x_coord_i,
  input  wire logic [nnm2d_pkg::COORD_W-1:0]   y_coord_i,
  output nnm2d_pkg::dp_status_t                status_o,
  output logic [nnm2d_pkg::IDX_W-1:0]          query_tag_o,
  output logic [nnm2d_pkg::IDX_W-1:0]          match_index_o,
  output logic                                 found_o,
  output logic [nnm2d_pkg::DIST_W-1:0]         min_dist_sq_o
);

  localparam int CW = nnm2d_pkg::COORD_W;

  logic [2*CW-1:0]                     mem_q [nnm2d_pkg::REF_DEPTH];
  logic [2*CW-1:0]                     rd_data_q;
  logic                                wr_ok;

  logic [CW-1:0]                       qx_q, qy_q;
  logic [nnm2d_pkg::IDX_W-1:0]         tag_q;

  logic                                v1_q, v2_q, v3_q;
  logic [nnm2d_pkg::ADDR_W-1:0]        idx1_q, idx2_q, idx3_q;

  logic [CW-1:0]                       ref_x, ref_y;
  logic [nnm2d_pkg::DIFF_W-1:0]        dx_d, dy_d;
  logic signed [nnm2d_pkg::DIFF_W-1:0] dx_q, dy_q;
  logic signed [2*nnm2d_pkg::DIFF_W-1:0] prod_x, prod_y;
  logic [nnm2d_pkg::SQ_W-1:0]          sq_x_q, sq_y_q;
  logic [nnm2d_pkg::DIST_W-1:0]        cur_dist;
  logic                                better;

  logic                                found_q;
  logic [nnm2d_pkg::DIST_W-1:0]        best_dist_q;
  logic [nnm2d_pkg::ADDR_W-1:0]        best_idx_q;

  // loads beyond the store are dropped
  assign wr_ok = nnm2d_pkg::CMP_W'(point_index_i) < nnm2d_pkg::CMP_W'(nnm2d_pkg::REF_DEPTH);

  // reference store, y in the upper half
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem_q[nnm2d_pkg::ADDR_W'(point_index_i)] <= {y_coord_i, x_coord_i};
    end
    rd_data_q <= mem_q[cmd_i.rd_addr];
  end

  // sign-extended differences
  assign ref_x = rd_data_q[CW-1:0];
  assign ref_y = rd_data_q[2*CW-1:CW];
  assign dx_d  = {ref_x[CW-1], ref_x} - {qx_q[CW-1], qx_q};
  assign dy_d  = {ref_y[CW-1], ref_y} - {qy_q[CW-1], qy_q};

  // squares never exceed 32 bits
  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  assign cur_dist = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign better   = !found_q || (cur_dist < best_dist_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      qx_q  <= x_coord_i;
      qy_q  <= y_coord_i;
      tag_q <= point_index_i;
    end
    idx1_q <= cmd_i.rd_addr;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sq_x_q <= prod_x[nnm2d_pkg::SQ_W-1:0];
    sq_y_q <= prod_y[nnm2d_pkg::SQ_W-1:0];
    if (cmd_i.query) begin
      best_dist_q <= '0;
      best_idx_q  <= '0;
    end else if (v3_q && better) begin
      best_dist_q <= cur_dist;
      best_idx_q  <= idx3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.query) begin
        found_q <= 1'b0;
      end else if (v3_q) begin
        found_q <= 1'b1;
      end
    end
  end

  assign status_o.pipe_busy = v1_q | v2_q | v3_q;

  assign query_tag_o   = tag_q;
  assign match_index_o = nnm2d_pkg::IDX_W'(best_idx_q);
  assign found_o       = found_q;
  assign min_dist_sq_o = best_dist_q;

endmodule

`default_nettype wire

@@ hdl/nearest_neighbor_match_2d_core.sv @@
// top level of the 2-d nearest neighbour matcher: controller plus datapath
// depends on nnm2d_pkg, nnm2d_ctrl and nnm2d_dp
`default_nettype none
// a load is written at acceptance and busy stays low; a query searching n points raises busy
//   and strobes its result after its scan and the pipeline drain
// a new query waits for the last result strobe; search time is set by the single read port
//   of the reference store walked one entry per cycle plus the three-stage distance pipeline
// reset clears the state machine, ref_count and pipeline valids; store contents are undefined
// until loaded; results are strobed for one cycle and the receiver cannot stall them

module nearest_neighbor_match_2d_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command transaction
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            op_i,
  input  wire logic [nnm2d_pkg::IDX_W-1:0]     point_index_i,
  input  wire logic [nnm2d_pkg::COORD_W-1:0]   x_coord_i,
  input  wire logic [nnm2d_pkg::COORD_W-1:0]   y_coord_i,
  // configuration transaction (ref_count)
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [nnm2d_pkg::CFG_W-1:0]     cfg_data_i,
  // result strobe
  output logic                                 result_valid_o,
  output logic [nnm2d_pkg::IDX_W-1:0]          query_tag_o,
  output logic [nnm2d_pkg::IDX_W-1:0]          match_index_o,
  output logic                                 found_o,
  output logic [nnm2d_pkg::DIST_W-1:0]         min_dist_sq_o
);

  // commands from the controller, pipeline status back from the datapath
  nnm2d_pkg::ctrl_cmd_t  cmd;
  nnm2d_pkg::dp_status_t status;

  // state machine: idle, scan (one store read per cycle), drain, done (result strobe)
  nnm2d_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .op_i           (op_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  // store, difference, square and compare stages; best match held until the next query
  nnm2d_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .point_index_i (point_index_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .status_o      (status),
    .query_tag_o   (query_tag_o),
    .match_index_o (match_index_o),
    .found_o       (found_o),
    .min_dist_sq_o (min_dist_sq_o)
  );

endmodule

`default_nettype wire

@@ hdl/nnm2d_checker.sv @@
// port-level checks of the nearest neighbour matcher, bound to the top level
// depends on nnm2d_pkg and nearest_neighbor_match_2d_core
`default_nettype none

module nnm2d_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            op_i,
  input wire logic                            result_valid_o,
  input wire logic [nnm2d_pkg::IDX_W-1:0]     match_index_o,
  input wire logic                            found_o,
  input wire logic [nnm2d_pkg::DIST_W-1:0]    min_dist_sq_o
);

  // a result is a single-cycle strobe
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // result only while a query is in progress
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // empty search reports zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (match_index_o == '0 && min_dist_sq_o == '0))
    else $error("empty search with non-zero match");

  // an accepted query occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == nnm2d_pkg::OP_QUERY) |=> busy)
    else $error("query accepted without going busy");

  // a load produces no result and leaves the block idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == nnm2d_pkg::OP_LOAD) |=> (!busy && !result_valid_o))
    else $error("load transaction disturbed the block");

endmodule

bind nearest_neighbor_match_2d_core nnm2d_checker u_nnm2d_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for nearest_neighbor_match_2d_core: directed and random stimulus
// depends on nnm2d_pkg and the core; predicts every query result from its own copy of the store
`timescale 1ns / 1ps

module tb;
  import nnm2d_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // a load has no result, so the core is given this long to finish one before a config write
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                 drain_first;
  } nn_cmd_t;

  typedef struct {
    logic [IDX_W-1:0]  tag;
    logic [IDX_W-1:0]  index;
    logic              found;
    logic [DIST_W-1:0] dist_sq;
  } nn_match_t;

  // clock, reset and every core input start at known values
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                op_i          = OP_LOAD;
  logic [IDX_W-1:0]    point_index_i = '0;
  logic [COORD_W-1:0]  x_coord_i     = '0;
  logic [COORD_W-1:0]  y_coord_i     = '0;
  logic                cfg_valid_i   = 1'b0;
  logic [CFG_W-1:0]    cfg_data_i    = '0;
  logic                busy;
  logic                cfg_ready_o;
  logic                result_valid_o;
  logic [IDX_W-1:0]    query_tag_o;
  logic [IDX_W-1:0]    match_index_o;
  logic                found_o;
  logic [DIST_W-1:0]   min_dist_sq_o;

  nearest_neighbor_match_2d_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .point_index_i  (point_index_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .query_tag_o    (query_tag_o),
    .match_index_o  (match_index_o),
    .found_o        (found_o),
    .min_dist_sq_o  (min_dist_sq_o)
  );

  always #4 clk_i = ~clk_i;

  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // predictor state: the store and ref_count as the core should hold them
  logic [COORD_W-1:0] store_x [REF_DEPTH];
  logic [COORD_W-1:0] store_y [REF_DEPTH];
  logic [CFG_W-1:0]   ref_count_cfg = '0;

  // stimulus plan: what the store will hold once the queued transactions are through,
  // used to aim queries near stored points and to never search an unwritten entry
  logic [COORD_W-1:0] plan_x [REF_DEPTH];
  logic [COORD_W-1:0] plan_y [REF_DEPTH];
  bit                 plan_loaded [REF_DEPTH];

  nn_cmd_t   pending_cmds[$];
  nn_match_t pending_matches[$];
  nn_cmd_t   cur_cmd;
  int        gap_pct = 12;
  int        mismatch_count = 0;

  // brute-force search over the first ref_count entries, lowest index wins a tie
  function automatic nn_match_t nearest_match(input nn_cmd_t c);
    nn_match_t m;
    int        span;
    longint    dx, dy, d, best;
    m.tag     = c.idx;
    m.index   = '0;
    m.found   = 1'b0;
    m.dist_sq = '0;
    best      = 0;
    // counts past the store saturate at its depth
    span = (int'(ref_count_cfg) > REF_DEPTH) ? REF_DEPTH : int'(ref_count_cfg);
    for (int j = 0; j < span; j++) begin
      dx = longint'($signed(store_x[j])) - longint'($signed(c.x));
      dy = longint'($signed(store_y[j])) - longint'($signed(c.y));
      d  = dx * dx + dy * dy;
      if (!m.found || d < best) begin
        best    = d;
        m.index = IDX_W'(j);
        m.found = 1'b1;
      end
    end
    m.dist_sq = DIST_W'(best);
    return m;
  endfunction

  // applies one accepted transaction to the predictor
  task automatic apply_command(input nn_cmd_t c);
    if (c.op == OP_LOAD) begin
      store_x[c.idx] = c.x;
      store_y[c.idx] = c.y;
    end else begin
      pending_matches.insert(pending_matches.size(), nearest_match(c));
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d at cycle %0d: %s expected %0h got %0h",
               mismatch_count, cycle_count, what, want, got);
  endtask

  // driver: a transaction is taken at an edge with start high and busy low
  always @(posedge clk_i) begin
    bit take_next;
    if (rst_ni) begin
      take_next = !start;
      if (start && !busy) begin
        apply_command(cur_cmd);
        take_next = 1'b1;
      end
      if (take_next) begin
        // random gaps, and a full drain when the item asks for one
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
            !(pending_cmds[0].drain_first && pending_matches.size() != 0)) begin
          cur_cmd       = pending_cmds.pop_front();
          start         <= 1'b1;
          op_i          <= cur_cmd.op;
          point_index_i <= cur_cmd.idx;
          x_coord_i     <= cur_cmd.x;
          y_coord_i     <= cur_cmd.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: a result is present for one cycle only and is checked at the edge that ends it
  always @(posedge clk_i) begin
    nn_match_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_matches.size() == 0) begin
        flag_mismatch("result with no query outstanding, tag", '0, 64'(query_tag_o));
      end else begin
        want = pending_matches.pop_front();
        if (query_tag_o !== want.tag)
          flag_mismatch("query_tag", 64'(want.tag), 64'(query_tag_o));
        if (match_index_o !== want.index)
          flag_mismatch("match_index", 64'(want.index), 64'(match_index_o));
        if (found_o !== want.found)
          flag_mismatch("found", 64'(want.found), 64'(found_o));
        if (min_dist_sq_o !== want.dist_sq)
          flag_mismatch("min_dist_sq", 64'(want.dist_sq), 64'(min_dist_sq_o));
      end
    end
  end

  // hard stop for a hung core or a lost result
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("nearest_neighbor_match_2d_core regression: fail");
    $finish;
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom_range(0, 16'hFFFF));
      1: return COORD_W'($urandom_range(0, 128) - 64);
      2: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h8001;
          3:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return COORD_W'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  task automatic plan_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input bit drain);
    nn_cmd_t c;
    c.op          = op;
    c.idx         = idx;
    c.x           = x;
    c.y           = y;
    c.drain_first = drain;
    pending_cmds.insert(pending_cmds.size(), c);
    if (op == OP_LOAD) begin
      plan_x[idx]      = x;
      plan_y[idx]      = y;
      plan_loaded[idx] = 1'b1;
    end
  endtask

  // waits until every queued transaction is in and every result is out, then lets any
  // trailing load finish
  task automatic settle();
    while (pending_cmds.size() != 0 || start || pending_matches.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // config transaction, only ever issued with the core idle
  task automatic set_ref_count(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ref_count_cfg = value;
  endtask

  // one random stretch: make sure the searched prefix is loaded, set the count, then mix
  // loads (some overwriting searched entries, some duplicating them for ties) with queries
  // aimed near stored points or anywhere
  task automatic random_block(input int n_items, input int max_span);
    int                 span, k, base, r;
    logic [COORD_W-1:0] qx, qy;
    span = $urandom_range(1, max_span);
    for (k = 0; k < span; k++)
      if (!plan_loaded[k]) plan_item(OP_LOAD, IDX_W'(k), rand_coord(), rand_coord(), 1'b0);
    set_ref_count(CFG_W'(span));
    for (k = 0; k < n_items; k++) begin
      base = $urandom_range(0, span - 1);
      r    = $urandom_range(0, 99);
      if (r < 15) begin
        plan_item(OP_LOAD, IDX_W'($urandom_range(0, 1023)), rand_coord(), rand_coord(), 1'b0);
      end else if (r < 22) begin
        // duplicate of a searched entry, so the lower index has to win
        plan_item(OP_LOAD, IDX_W'($urandom_range(0, span - 1)), plan_x[base], plan_y[base],
                  1'b0);
      end else if (r < 30) begin
        plan_item(OP_LOAD, IDX_W'($urandom_range(0, span - 1)), rand_coord(), rand_coord(),
                  1'b0);
      end else if (r < 60) begin
        qx = plan_x[base] + COORD_W'($urandom_range(0, 20) - 10);
        qy = plan_y[base] + COORD_W'($urandom_range(0, 20) - 10);
        plan_item(OP_QUERY, IDX_W'($urandom_range(0, 1023)), qx, qy,
                  $urandom_range(0, 49) == 0);
      end else begin
        plan_item(OP_QUERY, IDX_W'($urandom_range(0, 1023)), rand_coord(), rand_coord(),
                  $urandom_range(0, 49) == 0);
      end
    end
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty search straight after reset, tag echoed at both extremes
    plan_item(OP_QUERY, 10'd0, 16'h0000, 16'h0000, 1'b0);
    plan_item(OP_QUERY, 10'd1023, 16'h8000, 16'h7FFF, 1'b0);
    // corners, a duplicated pair, origin and minus one; the first load waits for a drain
    plan_item(OP_LOAD, 10'd0, 16'h8000, 16'h8000, 1'b1);
    plan_item(OP_LOAD, 10'd1, 16'h7FFF, 16'h7FFF, 1'b0);
    plan_item(OP_LOAD, 10'd2, 16'h8000, 16'h7FFF, 1'b0);
    plan_item(OP_LOAD, 10'd3, 16'h7FFF, 16'h8000, 1'b0);
    plan_item(OP_LOAD, 10'd4, 16'd100, 16'hFF38, 1'b0);
    plan_item(OP_LOAD, 10'd5, 16'd100, 16'hFF38, 1'b0);
    plan_item(OP_LOAD, 10'd6, 16'h0000, 16'h0000, 1'b0);
    plan_item(OP_LOAD, 10'd7, 16'hFFFF, 16'hFFFF, 1'b0);

    // single entry: largest possible distance, then an exact hit
    set_ref_count(11'd1);
    plan_item(OP_QUERY, 10'd1, 16'h7FFF, 16'h7FFF, 1'b0);
    plan_item(OP_QUERY, 10'd2, 16'h8000, 16'h8000, 1'b0);

    // ties between equal entries and between equidistant ones go to the lower index
    set_ref_count(11'd8);
    plan_item(OP_QUERY, 10'd3, 16'd100, 16'hFF38, 1'b0);
    plan_item(OP_QUERY, 10'd4, 16'h0000, 16'hFFFF, 1'b0);
    plan_item(OP_QUERY, 10'd5, 16'h8000, 16'h0000, 1'b1);
    plan_item(OP_QUERY, 10'd6, 16'h7FFF, 16'h7FFF, 1'b0);
    plan_item(OP_QUERY, 10'd7, 16'h7FFF, 16'h8000, 1'b0);

    // light sender gaps
    for (k = 0; k < 5; k++) random_block(32, (k == 2) ? 160 : 24);

    // heavy sender gaps
    settle();
    gap_pct = 49;
    for (k = 0; k < 5; k++) random_block(32, (k == 3) ? 160 : 24);

    // back to back, then empty searches once more
    settle();
    gap_pct = 0;
    for (k = 0; k < 5; k++) random_block(32, (k == 1) ? 160 : 24);
    set_ref_count('0);
    for (k = 0; k < 2; k++)
      plan_item(OP_QUERY, IDX_W'($urandom_range(0, 1023)), rand_coord(), rand_coord(), 1'b0);

    settle();
    if (mismatch_count == 0) begin
      $display("nearest_neighbor_match_2d_core regression: pass");
    end else begin
      $display("nearest_neighbor_match_2d_core regression: fail");
    end
    $finish;
  end

endmodule

@@ nearest_neighbor_match_2d_core.f @@
hdl/nnm2d_pkg.sv
hdl/nnm2d_ctrl.sv
hdl/nnm2d_dp.sv
hdl/nearest_neighbor_match_2d_core.sv
hdl/nnm2d_checker.sv
tb/tb.sv
